// ===== sv/two_level_page_table_macros.svh =====
// Assertion macros for the two-level page table.
// Included by the top level; depends on a clock named clock and a reset named reset.
`ifndef TWO_LEVEL_PAGE_TABLE_MACROS_SVH
`define TWO_LEVEL_PAGE_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TLPT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define TLPT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/tlpt_pkg.sv =====
// Types, sizes and codes for the two-level page table.
// No dependencies; imported by two_level_page_table.
`default_nettype none

package tlpt_pkg;

   // Table and directory sizes are powers of two.
   localparam int DIR_ENTRIES   = 1024;
   localparam int TABLE_ENTRIES = 1024;
   localparam int TABLE_SLOTS   = 16;

   localparam int DI_W      = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
   localparam int TI_W      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int SLOT_W    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int NS_W      = $clog2(TABLE_SLOTS + 1);
   localparam int TBL_AW    = SLOT_W + TI_W;
   localparam int TBL_DEPTH = TABLE_SLOTS * TABLE_ENTRIES;

   localparam int VPAGE_W = 20;
   localparam int FRAME_W = 20;
   localparam int FLAGS_W = 12;
   localparam int PTE_W   = FRAME_W + FLAGS_W;

   typedef enum logic [1:0] {
      CMD_MAP    = 2'd0,
      CMD_UNMAP  = 2'd1,
      CMD_LOOKUP = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_UNMAPPED = 2'd1,
      STAT_NO_SLOT  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_DIR,
      ST_CLEAR,
      ST_TBL,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [VPAGE_W-1:0] vpage;
      logic [FRAME_W-1:0] frame_in;
      logic [FLAGS_W-1:0] flags_in;
   } req_type;

   typedef struct packed {
      logic               mapped;
      logic [FRAME_W-1:0] frame_out;
      logic [FLAGS_W-1:0] flags_out;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic              present;
   } dir_entry_type;

endpackage

`default_nettype wire

// ===== sv/two_level_page_table.sv =====
// Two-level page table: directory memory, table memory and command sequencer.
// Depends on tlpt_pkg and two_level_page_table_macros.svh.
//
//   channel | ports                          | direction
//   req     | req_valid, req_ready, req_data | in  (cmd, vpage, frame_in, flags_in)
//   rsp     | rsp_valid, rsp_ready, rsp_data | out (mapped, frame_out, flags_out, status)
//
// Unmap, map into a present table and other commands: accept, then directory read.
// Lookup of a present directory entry: adds the table memory read.
// Map that allocates a table: adds a clearing pass, one table entry cleared per cycle.
// After reset, a pass over all DIR_ENTRIES entries clears the directory; req_ready stays low.
// A result waiting in the output register does not block the next transaction;
// a second finished result is held until the first is taken.
`default_nettype none
`include "two_level_page_table_macros.svh"

module two_level_page_table
   import tlpt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   dir_entry_type dir_mem [DIR_ENTRIES];
   logic [PTE_W-1:0] tbl_mem [TBL_DEPTH];

   state_type         state_ff, state_in;
   req_type           req_ff;
   dir_entry_type     dir_q_ff;
   logic [PTE_W-1:0]  tbl_q_ff;
   logic [DI_W-1:0]   init_cnt_ff;
   logic [TI_W-1:0]   clr_cnt_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [NS_W-1:0]   next_slot_ff;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff;
   rsp_type           hold_ff;

   logic [DI_W-1:0]   dir_raddr;
   logic [DI_W-1:0]   di;
   logic [TI_W-1:0]   ti;
   logic [TBL_AW-1:0] tbl_raddr;
   logic              dir_we;
   logic [DI_W-1:0]   dir_waddr;
   dir_entry_type     dir_wdata;
   logic              tbl_we;
   logic [TBL_AW-1:0] tbl_waddr;
   logic [PTE_W-1:0]  tbl_wdata;
   logic [PTE_W-1:0]  map_pte;
   logic              slot_avail;
   logic              init_last;
   logic              clr_last;
   logic              out_free;
   logic              alloc;
   logic              fin;
   rsp_type           res_c;

   assign dir_raddr  = req_data.vpage[TI_W +: DI_W];
   assign di         = req_ff.vpage[TI_W +: DI_W];
   assign ti         = req_ff.vpage[TI_W-1:0];
   assign tbl_raddr  = {dir_q_ff.slot, ti};
   assign map_pte    = {req_ff.frame_in, req_ff.flags_in};
   assign slot_avail = next_slot_ff < NS_W'(TABLE_SLOTS);
   assign init_last  = init_cnt_ff == DI_W'(DIR_ENTRIES - 1);
   assign clr_last   = clr_cnt_ff == TI_W'(TABLE_ENTRIES - 1);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      dir_q_ff <= dir_mem[dir_raddr];
      if (dir_we) begin
         dir_mem[dir_waddr] <= dir_wdata;
      end
   end

   always_ff @(posedge clock) begin
      tbl_q_ff <= tbl_mem[tbl_raddr];
      if (tbl_we) begin
         tbl_mem[tbl_waddr] <= tbl_wdata;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (init_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DIR;
            end
         end
         ST_DIR: begin
            if (alloc) begin
               state_in = ST_CLEAR;
            end else if (req_ff.cmd == CMD_LOOKUP && dir_q_ff.present) begin
               state_in = ST_TBL;
            end else begin
               state_in = out_free ? ST_IDLE : ST_HOLD;
            end
         end
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = out_free ? ST_IDLE : ST_HOLD;
            end
         end
         ST_TBL: begin
            state_in = out_free ? ST_IDLE : ST_HOLD;
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_comb begin
      fin       = 1'b0;
      alloc     = 1'b0;
      res_c     = '0;
      dir_we    = 1'b0;
      dir_waddr = init_cnt_ff;
      dir_wdata = '0;
      tbl_we    = 1'b0;
      tbl_waddr = {slot_ff, clr_cnt_ff};
      tbl_wdata = '0;
      unique case (state_ff)
         ST_INIT: begin
            dir_we = 1'b1;
         end
         ST_DIR: begin
            dir_waddr = di;
            unique case (req_ff.cmd)
               CMD_MAP: begin
                  if (dir_q_ff.present) begin
                     tbl_we    = 1'b1;
                     tbl_waddr = {dir_q_ff.slot, ti};
                     tbl_wdata = map_pte;
                     fin       = 1'b1;
                  end else if (slot_avail) begin
                     alloc             = 1'b1;
                     dir_we            = 1'b1;
                     dir_wdata.slot    = next_slot_ff[SLOT_W-1:0];
                     dir_wdata.present = req_ff.flags_in[0];
                  end else begin
                     fin          = 1'b1;
                     res_c.status = STAT_NO_SLOT;
                  end
               end
               CMD_UNMAP: begin
                  if (dir_q_ff.present) begin
                     tbl_we    = 1'b1;
                     tbl_waddr = {dir_q_ff.slot, ti};
                  end
                  fin = 1'b1;
               end
               CMD_LOOKUP: begin
                  if (!dir_q_ff.present) begin
                     fin          = 1'b1;
                     res_c.status = STAT_UNMAPPED;
                  end
               end
               default: begin
                  fin = 1'b1;
               end
            endcase
         end
         ST_CLEAR: begin
            tbl_we    = 1'b1;
            tbl_wdata = (clr_cnt_ff == ti) ? map_pte : '0;
            fin       = clr_last;
         end
         ST_TBL: begin
            fin = 1'b1;
            if (tbl_q_ff[0]) begin
               res_c.mapped    = 1'b1;
               res_c.frame_out = tbl_q_ff[PTE_W-1:FLAGS_W];
               res_c.flags_out = tbl_q_ff[FLAGS_W-1:0];
            end else begin
               res_c.status = STAT_UNMAPPED;
            end
         end
         ST_HOLD: begin
            fin   = 1'b1;
            res_c = hold_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_cnt_ff  <= '0;
         next_slot_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_INIT) begin
            init_cnt_ff <= init_cnt_ff + 1'b1;
         end
         if (alloc) begin
            next_slot_ff <= next_slot_ff + 1'b1;
         end
         if (fin && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (alloc) begin
         slot_ff    <= next_slot_ff[SLOT_W-1:0];
         clr_cnt_ff <= '0;
      end else if (state_ff == ST_CLEAR) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
      if (fin && out_free) begin
         rsp_ff <= res_c;
      end
      if (fin && !out_free) begin
         hold_ff <= res_c;
      end
   end

   `TLPT_ASSERT_NEXT(a_accept_reads_dir, req_valid && req_ready, state_ff == ST_DIR,
      "accepted transaction did not move to the directory read")
   `TLPT_ASSERT_NOW(a_slot_bound, 1'b1, next_slot_ff <= NS_W'(TABLE_SLOTS),
      "slot counter beyond table slots")
   `TLPT_ASSERT_NOW(a_clear_counted, state_ff == ST_CLEAR, NS_W'(slot_ff) < next_slot_ff,
      "clearing a table slot that was not allocated")
   `TLPT_ASSERT_NEXT(a_hold_keeps_result, state_ff != ST_HOLD && fin && !out_free,
      state_ff == ST_HOLD && rsp_valid_ff, "finished result not held behind a waiting response")

endmodule

`default_nettype wire
